[src/wth_pkg.sv]
//------------------------------------------------------------------------------
// wth_pkg - shared types and constants for the word tokenizer / hasher
// Character classes, configuration register indexes, widths and helpers.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package wth_pkg;

  // Configuration register indexes
  localparam logic REG_HASH_MODE  = 1'b0;
  localparam logic REG_TABLE_SIZE = 1'b1;

  localparam int CFG_W  = 17;   // widest register (table_size)
  localparam int HASH_W = 32;
  localparam int LEN_W  = 10;
  localparam int BKT_W  = 16;
  localparam int CNT_W  = 32;

  localparam int MAX_WORD_LEN = 1023;
  localparam int LEN_FIELD_MAX = 1023;
  localparam logic [LEN_W-1:0] LEN_LIMIT =
    LEN_W'((MAX_WORD_LEN < LEN_FIELD_MAX) ? MAX_WORD_LEN : LEN_FIELD_MAX);

  localparam logic [CFG_W-1:0] TABLE_SIZE_RST = 17'd1024;
  localparam logic [CFG_W-1:0] TABLE_SIZE_MAX = 17'd65536;

  // Hash modes
  localparam logic [1:0] MODE_DIV = 2'd0;
  localparam logic [1:0] MODE_ADD = 2'd1;
  localparam logic [1:0] MODE_XOR = 2'd2;

  localparam logic [7:0] CHAR_UC_A = 8'h41;
  localparam logic [7:0] CHAR_UC_Z = 8'h5A;
  localparam logic [7:0] CASE_OFS  = 8'h20;

  // Word delimiter set
  function automatic logic is_delim(input logic [7:0] c);
    logic d;
    case (c)
      8'h00, 8'h20, 8'h09, 8'h0A, 8'h0D,
      8'h2E, 8'h2C, 8'h3A, 8'h3B,
      8'h28, 8'h29, 8'h5B, 8'h5D, 8'h7B, 8'h7D,
      8'h3F, 8'h21, 8'h22, 8'h2D: d = 1'b1;
      default: d = 1'b0;
    endcase
    return d;
  endfunction

  // Clamp table size into 1..65536
  function automatic logic [CFG_W-1:0] eff_size(input logic [CFG_W-1:0] t);
    logic [CFG_W-1:0] r;
    if (t == '0) begin
      r = 17'd1;
    end else if (t > TABLE_SIZE_MAX) begin
      r = TABLE_SIZE_MAX;
    end else begin
      r = t;
    end
    return r;
  endfunction

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_DIV  = 3'b010,
    ST_EMIT = 3'b100
  } state_t;

  // Divider handshake
  typedef struct packed {
    logic              start;
    logic [HASH_W-1:0] dividend;
    logic [CFG_W-1:0]  divisor;
  } div_req_t;

endpackage

`default_nettype wire

[src/wth_divu.sv]
//------------------------------------------------------------------------------
// wth_divu - bit-serial remainder unit
// Restoring remainder of a 32-bit dividend by a divisor in 1..65536,
// one dividend bit per cycle.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module wth_divu (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire wth_pkg::div_req_t            req,
  output logic                              done,
  output logic [wth_pkg::BKT_W-1:0]         rem
);

  logic                        busy;
  logic [4:0]                  step;
  logic [wth_pkg::HASH_W-1:0]  dvd;
  logic [wth_pkg::CFG_W-1:0]   dsr;
  logic [wth_pkg::BKT_W-1:0]   rem_next;
  logic [wth_pkg::CFG_W-1:0]   trial;

  // Shift in the next dividend bit, subtract when it fits
  always_comb begin
    trial = {rem, dvd[wth_pkg::HASH_W-1]};
    if (trial >= dsr) begin
      rem_next = wth_pkg::BKT_W'(trial - dsr);
    end else begin
      rem_next = trial[wth_pkg::BKT_W-1:0];
    end
  end

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + 5'd1;
        if (step == 5'd31) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (req.start) begin
      dvd <= req.dividend;
      dsr <= req.divisor;
      rem <= '0;
    end else if (busy) begin
      dvd <= {dvd[wth_pkg::HASH_W-2:0], 1'b0};
      rem <= rem_next;
    end
  end

endmodule

`default_nettype wire

[src/word_tokenize_hash.sv]
//------------------------------------------------------------------------------
// word_tokenize_hash - text word splitter with per-word bucket hash
// Flow: additive / xor-rotate word bytes and delimiters outside a word never stall;
//   a division-mode byte stalls the input for load, 32 remainder steps and write.
// A word end passes the divider and emit state into the output register; the next
//   transaction is taken in the following cycle, or once a stalled result leaves.
// Reset (rst, synchronous): registers to hash_mode 0, table_size 1024; no word.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module word_tokenize_hash (
  input  wire logic                        clk,
  input  wire logic                        rst,
  // configuration
  input  wire logic                        cfg_we,
  input  wire logic                        cfg_index,
  input  wire logic [wth_pkg::CFG_W-1:0]   cfg_data,
  // input channel
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [7:0]                  text_byte,
  input  wire logic                        end_of_text,
  // output channel
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic [wth_pkg::BKT_W-1:0]        bucket,
  output logic [wth_pkg::LEN_W-1:0]        word_length,
  output logic [wth_pkg::CNT_W-1:0]        word_number
);

  logic [1:0]                   hash_mode;
  logic [wth_pkg::CFG_W-1:0]    table_size;
  logic [wth_pkg::HASH_W-1:0]   hash_accum;
  logic [wth_pkg::LEN_W-1:0]    token_len;
  logic                         in_word;
  logic [wth_pkg::CNT_W-1:0]    word_total;
  wth_pkg::state_t              state;
  logic                         op_finish;

  logic                         in_fire;
  logic                         is_end;
  logic [7:0]                   ch;
  logic [wth_pkg::HASH_W-1:0]   h_cur;
  logic [wth_pkg::LEN_W-1:0]    len_cur;
  logic [wth_pkg::HASH_W-1:0]   h_xor;
  wth_pkg::div_req_t            div_req;
  logic                         div_done;
  logic [wth_pkg::BKT_W-1:0]    div_rem;
  logic                         out_free;

  assign in_stall = (state != wth_pkg::ST_IDLE);
  assign in_fire  = in_valid && !in_stall;
  assign is_end   = end_of_text || wth_pkg::is_delim(text_byte);
  assign out_free = !out_valid || !out_stall;

  // Lower-case A-Z; start a fresh word from zero
  always_comb begin
    if (text_byte >= wth_pkg::CHAR_UC_A && text_byte <= wth_pkg::CHAR_UC_Z) begin
      ch = text_byte + wth_pkg::CASE_OFS;
    end else begin
      ch = text_byte;
    end
    h_cur   = in_word ? hash_accum : '0;
    len_cur = in_word ? token_len : '0;
    h_xor   = h_cur ^ {24'd0, ch};
  end

  // Divider request: per-byte reduction in mode 0, or final bucket reduction
  always_comb begin
    div_req.start    = 1'b0;
    div_req.divisor  = wth_pkg::eff_size(table_size);
    div_req.dividend = hash_accum;
    if (in_fire) begin
      if (is_end) begin
        div_req.start = in_word;
      end else if (hash_mode == wth_pkg::MODE_DIV) begin
        div_req.start    = 1'b1;
        div_req.dividend = {h_cur[24:0], 7'd0} + {24'd0, ch};
      end
    end
  end

  wth_divu u_divu (
    .clk  (clk),
    .rst  (rst),
    .req  (div_req),
    .done (div_done),
    .rem  (div_rem)
  );

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      hash_mode  <= wth_pkg::MODE_DIV;
      table_size <= wth_pkg::TABLE_SIZE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        wth_pkg::REG_HASH_MODE:  hash_mode  <= cfg_data[1:0];
        wth_pkg::REG_TABLE_SIZE: table_size <= cfg_data;
        default: ;
      endcase
    end
  end

  // Sequencer and word state
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= wth_pkg::ST_IDLE;
      in_word    <= 1'b0;
      word_total <= '0;
      hash_accum <= '0;
      token_len  <= '0;
      op_finish  <= 1'b0;
    end else begin
      case (state)
        wth_pkg::ST_IDLE: begin
          if (in_fire) begin
            if (is_end) begin
              if (in_word) begin
                in_word   <= 1'b0;
                op_finish <= 1'b1;
                state     <= wth_pkg::ST_DIV;
                if (word_total != '1) begin
                  word_total <= word_total + 32'd1;
                end
              end
            end else begin
              in_word   <= 1'b1;
              op_finish <= 1'b0;
              token_len <= (len_cur < wth_pkg::LEN_LIMIT) ? len_cur + 10'd1 : len_cur;
              case (hash_mode)
                wth_pkg::MODE_DIV: state <= wth_pkg::ST_DIV;
                wth_pkg::MODE_ADD: hash_accum <= h_cur + {24'd0, ch};
                default:           hash_accum <= {h_xor[27:0], h_cur[31:28]};
              endcase
            end
          end
        end
        wth_pkg::ST_DIV: begin
          if (div_done) begin
            if (op_finish) begin
              state <= wth_pkg::ST_EMIT;
            end else begin
              hash_accum <= {16'd0, div_rem};
              state      <= wth_pkg::ST_IDLE;
            end
          end
        end
        wth_pkg::ST_EMIT: begin
          if (out_free) begin
            state <= wth_pkg::ST_IDLE;
          end
        end
        default: state <= wth_pkg::ST_IDLE;
      endcase
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == wth_pkg::ST_EMIT && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == wth_pkg::ST_EMIT && out_free) begin
      bucket      <= div_rem;
      word_length <= token_len;
      word_number <= word_total;
    end
  end

endmodule

`default_nettype wire

[src/wth_chk.sv]
//------------------------------------------------------------------------------
// wth_chk - port-level checks for word_tokenize_hash
// Watches the channels over time; bound to the top level below.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module wth_chk (
  input wire logic                        clk,
  input wire logic                        rst,
  input wire logic                        in_stall,
  input wire logic                        out_valid,
  input wire logic                        out_stall,
  input wire logic [wth_pkg::BKT_W-1:0]   bucket,
  input wire logic [wth_pkg::LEN_W-1:0]   word_length,
  input wire logic [wth_pkg::CNT_W-1:0]   word_number
);

  // Reset leaves the block ready and with no result
  a_reset_idle: assert property (@(posedge clk) rst |=> !in_stall && !out_valid)
    else $error("block not idle after reset");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(bucket) &&
      $stable(word_length) && $stable(word_number))
    else $error("stalled result changed");

  // Every reported word is non-empty and counted
  a_word_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> word_length != '0 && word_number != '0)
    else $error("empty word or zero word number");

  // A transaction is never shown twice
  a_no_repeat: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall |=> !out_valid || word_number != $past(word_number) ||
      $past(word_number) == '1)
    else $error("result repeated");

endmodule

bind word_tokenize_hash wth_chk u_wth_chk (
  .clk         (clk),
  .rst         (rst),
  .in_stall    (in_stall),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .bucket      (bucket),
  .word_length (word_length),
  .word_number (word_number)
);

`default_nettype wire

[test/tb.sv]
//------------------------------------------------------------------------------
// tb - self-checking testbench for word_tokenize_hash
// Streams text bytes through the tokenizer under every hash mode and many
// table sizes. A behavioral copy of the splitter and hashes predicts each word
// result, and the monitor checks bucket, length and count field by field.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import wth_pkg::*;

  typedef struct packed {
    logic [BKT_W-1:0] bkt;
    logic [LEN_W-1:0] len;
    logic [CNT_W-1:0] num;
  } word_res_t;

  typedef struct packed {
    logic [7:0] chr;
    logic       eot;
    logic       fixed;   // result typed in below, not taken from the predictor
    word_res_t  res;
  } dir_row_t;

  localparam int N_DIR = 25;
  localparam int N_SEP = 19;
  localparam int N_PLAN = 8;
  localparam int N_PHASE = 16;
  localparam int SETTLE = 48;   // longer than a word end takes to reach the output
  localparam logic [1:0] MODE_SPARE = 2'd3;

  // space, tab, LF, CR, . , : ; ( ) [ ] { } ? ! " - and NUL
  localparam logic [7:0] SEP_SET [N_SEP] = '{
    8'h00, 8'h20, 8'h09, 8'h0A, 8'h0D, 8'h2E, 8'h2C, 8'h3A, 8'h3B, 8'h28,
    8'h29, 8'h5B, 8'h5D, 8'h7B, 8'h7D, 8'h3F, 8'h21, 8'h22, 8'h2D
  };

  // Fixed settings first, extremes among them; random settings follow
  localparam logic [1:0] PLAN_MODE [N_PLAN] = '{
    MODE_XOR, MODE_SPARE, MODE_DIV, MODE_DIV, MODE_ADD, MODE_XOR, MODE_DIV, MODE_ADD
  };
  localparam logic [CFG_W-1:0] PLAN_SIZE [N_PLAN] = '{
    TABLE_SIZE_MAX, 17'h1FFFF, 17'd1, 17'd0, 17'd65535, 17'd3, TABLE_SIZE_MAX, 17'd2
  };

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic cfg_index = REG_HASH_MODE;
  logic [CFG_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic [7:0] text_byte = 8'h00;
  logic end_of_text = 1'b0;
  logic out_stall = 1'b0;
  logic in_stall;
  logic out_valid;
  logic [BKT_W-1:0] bucket;
  logic [LEN_W-1:0] word_length;
  logic [CNT_W-1:0] word_number;

  // Predictor state and its copy of the registers
  logic [1:0]       cur_mode = MODE_DIV;
  logic [CFG_W-1:0] cur_size = TABLE_SIZE_RST;
  logic [31:0]      hash_acc = '0;
  logic [LEN_W-1:0] tok_len = '0;
  logic             word_open = 1'b0;
  logic [CNT_W-1:0] words_done = '0;

  word_res_t words_due [$];
  dir_row_t  dir_rows [N_DIR];

  bit tx_jitter = 1'b1;
  bit rx_jitter = 1'b1;
  int err_count = 0;
  int bytes_sent = 0;
  int words_checked = 0;
  int settings_used = 0;
  int longest_len = 0;

  word_tokenize_hash DUT (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .text_byte   (text_byte),
    .end_of_text (end_of_text),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .bucket      (bucket),
    .word_length (word_length),
    .word_number (word_number)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Run limit
  initial begin
    #10ms;
    $display("CHECK FAILED");
    $finish;
  end

  task automatic flag_error(input string msg);
    err_count++;
    $display("ERROR %0t: %s", $time, msg);
  endtask

  function automatic bit is_sep(input logic [7:0] b);
    bit hit;
    hit = 1'b0;
    for (int i = 0; i < N_SEP; i++) begin
      if (SEP_SET[i] == b) hit = 1'b1;
    end
    return hit;
  endfunction

  // Out-of-range sizes clamp into 1..65536
  function automatic logic [31:0] eff_buckets(input logic [CFG_W-1:0] t);
    logic [31:0] n;
    if (t == '0) begin
      n = 32'd1;
    end else if (t > TABLE_SIZE_MAX) begin
      n = 32'(TABLE_SIZE_MAX);
    end else begin
      n = 32'(t);
    end
    return n;
  endfunction

  // Advance the tokenizer by one transaction; returns 1 when a word closes
  function automatic bit tokenize_byte(input logic [7:0] chr, input logic eot,
                                       output word_res_t res);
    logic [31:0] c;
    res = '0;
    if (eot || is_sep(chr)) begin
      if (!word_open) return 1'b0;
      if (words_done != '1) words_done++;
      res.bkt = BKT_W'(hash_acc % eff_buckets(cur_size));
      res.len = tok_len;
      res.num = words_done;
      hash_acc = '0;
      tok_len = '0;
      word_open = 1'b0;
      return 1'b1;
    end
    c = (chr >= CHAR_UC_A && chr <= CHAR_UC_Z) ? 32'(chr + CASE_OFS) : 32'(chr);
    if (!word_open) begin
      word_open = 1'b1;
      hash_acc = '0;
      tok_len = '0;
    end
    case (cur_mode)
      MODE_DIV: hash_acc = (hash_acc * 32'd128 + c) % eff_buckets(cur_size);
      MODE_ADD: hash_acc = hash_acc + c;
      default:  hash_acc = ((hash_acc ^ c) << 4) | (hash_acc >> 28);
    endcase
    if (tok_len < LEN_LIMIT) tok_len++;
    return 1'b0;
  endfunction

  // One input transaction, with an optional random gap in front
  task automatic put_byte(input logic [7:0] chr, input logic eot,
                          input logic fixed = 1'b0, input word_res_t fixed_res = '0);
    word_res_t res;
    bit closed;
    if (tx_jitter && $urandom_range(99) < 23) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_valid <= 1'b1;
    text_byte <= chr;
    end_of_text <= eot;
    do @(posedge clk); while (in_stall);
    bytes_sent++;
    closed = tokenize_byte(chr, eot, res);
    if (fixed) begin
      words_due.push_back(fixed_res);
    end else if (closed) begin
      words_due.push_back(res);
    end
  endtask

  // Hold the sender until every word is back, then let the block settle
  task automatic quiesce(input int extra);
    in_valid <= 1'b0;
    do @(posedge clk); while (words_due.size() != 0);
    repeat (extra) @(posedge clk);
  endtask

  task automatic program_table(input logic [1:0] mode, input logic [CFG_W-1:0] size);
    cfg_we <= 1'b1;
    cfg_index <= REG_HASH_MODE;
    cfg_data <= CFG_W'(mode);
    @(posedge clk);
    cfg_index <= REG_TABLE_SIZE;
    cfg_data <= size;
    @(posedge clk);
    cfg_we <= 1'b0;
    cur_mode = mode;
    cur_size = size;
    settings_used++;
  endtask

  // Mostly letters of either case, otherwise any non-delimiter byte
  function automatic logic [7:0] rand_word_char();
    logic [7:0] b;
    if ($urandom_range(99) < 60) begin
      b = ($urandom_range(1) ? CHAR_UC_A : 8'h61) + 8'($urandom_range(25));
    end else begin
      do b = 8'($urandom_range(255)); while (is_sep(b));
    end
    return b;
  endfunction

  task automatic put_word(input int len);
    for (int i = 0; i < len; i++) put_byte(rand_word_char(), 1'b0);
  endtask

  function automatic int pick_len();
    int r;
    r = $urandom_range(99);
    if (r < 80) return $urandom_range(1, 8);
    if (r < 95) return $urandom_range(9, 40);
    return $urandom_range(41, 120);
  endfunction

  // Well-formed words with random content, plus stray bytes and cut-off words
  task automatic put_text(input int n_items, input bit hold_mid);
    int start;
    int r;
    start = bytes_sent;
    while (bytes_sent - start < n_items) begin
      r = $urandom_range(99);
      if (r < 80) begin
        put_word(pick_len());
        if ($urandom_range(9) == 0) begin
          put_byte(8'($urandom_range(255)), 1'b1);
        end else begin
          repeat ($urandom_range(1, 2)) put_byte(SEP_SET[$urandom_range(N_SEP - 1)], 1'b0);
        end
      end else if (r < 90) begin
        put_byte(8'($urandom_range(255)), 1'b0);
      end else if (r < 95) begin
        put_byte(8'($urandom_range(255)), 1'b1);
      end else begin
        put_word($urandom_range(1, 4));
      end
      if (hold_mid && bytes_sent - start >= n_items / 2) begin
        quiesce(0);
        hold_mid = 1'b0;
      end
    end
    // leave a word open so the next setting applies to its tail
    if ($urandom_range(1)) put_word($urandom_range(1, 3));
  endtask

  // Output side: random stalls and the field-by-field check
  always @(posedge clk) begin : word_check
    word_res_t due;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (words_due.size() == 0) begin
          flag_error($sformatf("unexpected word: bucket %0d length %0d number %0d",
                               bucket, word_length, word_number));
        end else begin
          due = words_due.pop_front();
          words_checked++;
          if (int'(word_length) > longest_len) longest_len = int'(word_length);
          if (bucket !== due.bkt)
            flag_error($sformatf("word %0d: bucket %0d, want %0d", due.num, bucket, due.bkt));
          if (word_length !== due.len)
            flag_error($sformatf("word %0d: length %0d, want %0d",
                                 due.num, word_length, due.len));
          if (word_number !== due.num)
            flag_error($sformatf("word number %0d, want %0d", word_number, due.num));
        end
      end
      out_stall <= rx_jitter && ($urandom_range(99) < 23);
    end
  end

  initial begin : stimulus
    logic [1:0] mode;
    logic [CFG_W-1:0] size;
    int r;

    // Directed rows, reset settings: division hash, 1024 buckets
    dir_rows = '{
      '{8'h71, 1'b1, 1'b0, '0},                          // end of text, no word
      '{8'h00, 1'b0, 1'b0, '0},                          // NUL outside a word
      '{8'h41, 1'b0, 1'b0, '0},                          // 'A' lower-cased
      '{8'h20, 1'b0, 1'b1, '{16'd97, 10'd1, 32'd1}},
      '{8'h5A, 1'b0, 1'b0, '0},                          // 'Z'
      '{8'h41, 1'b1, 1'b1, '{16'd122, 10'd1, 32'd2}},    // byte ignored on end of text
      '{8'h40, 1'b0, 1'b0, '0},                          // '@' just below 'A'
      '{8'h2D, 1'b0, 1'b1, '{16'd64, 10'd1, 32'd3}},
      '{8'h5B, 1'b0, 1'b0, '0},                          // '[' just above 'Z'
      '{8'h60, 1'b0, 1'b0, '0},
      '{8'h7B, 1'b0, 1'b1, '{16'd96, 10'd1, 32'd4}},
      '{8'h61, 1'b0, 1'b0, '0},
      '{8'h7A, 1'b0, 1'b0, '0},
      '{8'h09, 1'b0, 1'b0, '0},
      '{8'hFF, 1'b0, 1'b0, '0},
      '{8'h80, 1'b0, 1'b0, '0},
      '{8'h7F, 1'b0, 1'b0, '0},
      '{8'h0A, 1'b0, 1'b0, '0},
      '{8'h7E, 1'b0, 1'b0, '0},
      '{8'h0D, 1'b0, 1'b0, '0},
      '{8'h01, 1'b0, 1'b0, '0},
      '{8'h22, 1'b0, 1'b0, '0},
      '{8'h3F, 1'b0, 1'b0, '0},
      '{8'hFE, 1'b0, 1'b0, '0},
      '{8'hFF, 1'b1, 1'b0, '0}
    };

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < N_DIR; i++) begin
      put_byte(dir_rows[i].chr, dir_rows[i].eot, dir_rows[i].fixed, dir_rows[i].res);
    end

    // Length saturation: one word just past the limit
    quiesce(SETTLE);
    program_table(MODE_ADD, TABLE_SIZE_RST);
    put_word(int'(LEN_LIMIT) + $urandom_range(1, 4));
    put_byte(8'h20, 1'b0);

    // Random text under a sequence of settings; phase 4 runs longer without jitter
    for (int p = 0; p < N_PHASE; p++) begin
      quiesce(SETTLE);
      if (p < N_PLAN) begin
        mode = PLAN_MODE[p];
        size = PLAN_SIZE[p];
      end else begin
        mode = 2'($urandom_range(3));
        r = $urandom_range(99);
        if (r < 30) size = CFG_W'($urandom_range(1, 64));
        else if (r < 60) size = CFG_W'($urandom_range(65, 4096));
        else if (r < 85) size = CFG_W'($urandom_range(4097, 65536));
        else size = CFG_W'($urandom_range(65537, 131071));
      end
      program_table(mode, size);
      tx_jitter = (p != 4);
      rx_jitter = (p != 4);
      put_text((p == 4) ? 60 : 16, p == 1 || $urandom_range(3) == 0);
    end

    quiesce(SETTLE);
    $display("Sent %0d byte transactions across %0d table settings in all hash modes",
             bytes_sent, settings_used);
    $display("Checked %0d words, longest reported length %0d", words_checked, longest_len);
    if (err_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
